>>> sv/hgbl_pkg.sv
// Package for the height grid bilinear lookup unit.
// Holds action codes, register indexes and fixed widths; no dependencies.
package hgbl_pkg;

	typedef enum logic [1:0] {
		ACT_WRITE  = 2'd0,
		ACT_INTERP = 2'd1,
		ACT_READ   = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	localparam logic [2:0] REG_ORIGIN_X = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [2:0] REG_PITCH    = 3'd2;
	localparam logic [2:0] REG_COLS     = 3'd3;
	localparam logic [2:0] REG_ROWS     = 3'd4;
	localparam logic [2:0] REG_READY    = 3'd5;

	localparam logic [30:0] MIN_PITCH = 31'd6554;
	localparam int IN_W  = 120;
	localparam int OUT_W = 40;
	localparam int DIV_W = 49;

endpackage

>>> sv/height_grid_bilinear_lookup_unit.sv
// Height grid with coverage bits and bilinear lookup, top level.
// Depends on hgbl_pkg; holds the grid memory, divider and blend datapath.
//
//  channel | direction | handshake        | contents
//  s_*     | in        | tvalid / tready  | action, cell, sample height, query point
//  m_*     | out       | tvalid / tready  | ok flag, height
//  cfg_*   | in        | cfg_we           | origin, pitch, counts, ready flag
//
// After reset a clearing pass walks every grid entry, and no transaction is
// accepted until it ends. A write, or a request that fails before any read,
// goes straight to the result (an interpolation through its range check first),
// a cell read makes one read, and an interpolation runs the bit-serial divider and
// then up to four reads in turn on the single memory read port.
// A finished result sits in the output register; a new transaction is accepted
// while it waits, and the block stalls only when the next result is ready.
module height_grid_bilinear_lookup_unit #(
	parameter int MAX_COLUMNS = 256,
	parameter int MAX_ROWS    = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// action[1:0], cell_col[9:2], cell_row[17:10], sample_height[49:18],
	// point_x[81:50], point_y[113:82], zeros above
	input  logic [hgbl_pkg::IN_W-1:0]    s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// ok[0], height_out[32:1], zeros above
	output logic [hgbl_pkg::OUT_W-1:0]   m_tdata,
	input  logic                         cfg_we,
	input  logic [2:0]                   cfg_index,
	input  logic [31:0]                  cfg_wdata
);
	import hgbl_pkg::*;

	localparam int CELLS = MAX_ROWS * MAX_COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CIW   = $clog2(MAX_COLUMNS);
	localparam int RIW   = $clog2(MAX_ROWS);
	localparam int CNW   = $clog2(MAX_COLUMNS + 1);
	localparam int RNW   = $clog2(MAX_ROWS + 1);
	localparam int LXW   = 31 + CNW;
	localparam int LYW   = 31 + RNW;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CHECK, ST_DIVIDE, ST_SETUP, ST_READ, ST_FINISH
	} state_t;

	// Configuration registers.
	logic signed [31:0] origin_x_q, origin_y_q;
	logic [30:0] pitch_q;
	logic [8:0] cols_q, rows_q;
	logic ready_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			pitch_q    <= 31'd65536;
			cols_q     <= 9'd1;
			rows_q     <= 9'd1;
			ready_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ORIGIN_X: origin_x_q <= cfg_wdata;
				REG_ORIGIN_Y: origin_y_q <= cfg_wdata;
				REG_PITCH:    pitch_q    <= cfg_wdata[30:0];
				REG_COLS:     cols_q     <= cfg_wdata[8:0];
				REG_ROWS:     rows_q     <= cfg_wdata[8:0];
				REG_READY:    ready_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Effective geometry: counts clamped to 1..max, pitch floored at 0.1 mm.
	logic [30:0] pitch;
	logic [CNW-1:0] cols_eff;
	logic [RNW-1:0] rows_eff;
	logic [LXW-1:0] lim_x;
	logic [LYW-1:0] lim_y;

	always_comb begin
		pitch = (pitch_q < MIN_PITCH) ? MIN_PITCH : pitch_q;
		if (cols_q == 9'd0) cols_eff = CNW'(1);
		else if (32'(cols_q) > 32'(MAX_COLUMNS)) cols_eff = CNW'(MAX_COLUMNS);
		else cols_eff = CNW'(cols_q);
		if (rows_q == 9'd0) rows_eff = RNW'(1);
		else if (32'(rows_q) > 32'(MAX_ROWS)) rows_eff = RNW'(MAX_ROWS);
		else rows_eff = RNW'(rows_q);
		lim_x = LXW'(pitch) * LXW'(cols_eff - CNW'(1));
		lim_y = LYW'(pitch) * LYW'(rows_eff - RNW'(1));
	end

	// Input fields.
	logic [1:0] in_action;
	logic [7:0] in_col, in_row;
	logic [31:0] in_height, in_px, in_py;
	logic in_inside;

	assign in_action = s_tdata[1:0];
	assign in_col    = s_tdata[9:2];
	assign in_row    = s_tdata[17:10];
	assign in_height = s_tdata[49:18];
	assign in_px     = s_tdata[81:50];
	assign in_py     = s_tdata[113:82];
	assign in_inside = (32'(in_col) < 32'(cols_eff)) && (32'(in_row) < 32'(rows_eff));

	// Control and datapath registers.
	state_t st_q;
	logic clr_done_q;
	logic [AW-1:0] clr_q;
	logic okflag_q, wr_q, cov_q;
	logic signed [33:0] dx_q, dy_q;
	logic [DIV_W-1:0] qx_q, qy_q;
	logic [31:0] rx_q, ry_q;
	logic [5:0] dcnt_q;
	logic [CIW-1:0] ix_q;
	logic [RIW-1:0] iy_q;
	logic [15:0] fx_q, fy_q;
	logic [2:0] k_q, n_q;
	logic signed [65:0] acc_q;

	logic accept;
	assign s_tready = clr_done_q && (st_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// One restoring division step for each axis.
	logic [31:0] tx, ty;
	logic bx, by;
	always_comb begin
		tx = {rx_q[30:0], qx_q[DIV_W-1]};
		ty = {ry_q[30:0], qy_q[DIV_W-1]};
		bx = tx >= {1'b0, pitch};
		by = ty >= {1'b0, pitch};
	end

	// Memory access: entry is {covered, height}.
	logic [32:0] mem [CELLS];
	logic mem_we;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [32:0] wr_data;
	logic rd_en;
	logic [32:0] rd_q;
	logic [CIW-1:0] rcol;
	logic [RIW-1:0] rrow;
	logic [16:0] wx, wy;
	logic [32:0] w_c;

	always_comb begin
		mem_we  = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		if (!clr_done_q) begin
			mem_we = 1'b1;
		end else if (accept && in_action == ACT_WRITE && in_inside) begin
			mem_we  = 1'b1;
			wr_addr = AW'(32'(RIW'(in_row)) * MAX_COLUMNS + 32'(CIW'(in_col)));
			wr_data = {1'b1, in_height};
		end
		rd_en = (st_q == ST_READ) && (k_q != n_q);
		rcol  = ix_q + CIW'(k_q[0]);
		rrow  = iy_q + RIW'(k_q[1]);
		rd_addr = AW'(32'(rrow) * MAX_COLUMNS + 32'(rcol));
		wx = k_q[0] ? {1'b0, fx_q} : (17'h10000 - {1'b0, fx_q});
		wy = k_q[1] ? {1'b0, fy_q} : (17'h10000 - {1'b0, fy_q});
		w_c = 33'(34'(wx) * 34'(wy));
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// Weight and product pipeline.
	logic v_s1, v_s2, cov_s2;
	logic [32:0] w_s1;
	logic signed [65:0] prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		w_s1    <= w_c;
		prod_s2 <= $signed(rd_q[31:0]) * $signed({1'b0, w_s1});
		cov_s2  <= rd_q[32];
	end

	// Final result: sum of weighted heights, rounded half up at bit 32.
	logic signed [65:0] rnd;
	logic res_ok;
	assign rnd    = acc_q + 66'sd2147483648;
	assign res_ok = okflag_q && cov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			clr_done_q <= 1'b0;
			clr_q      <= '0;
			m_tvalid   <= 1'b0;
			m_tdata    <= '0;
			okflag_q   <= 1'b0;
			wr_q       <= 1'b0;
			cov_q      <= 1'b1;
			dcnt_q     <= '0;
			k_q        <= '0;
			n_q        <= '0;
		end else begin
			if (m_tvalid && m_tready && st_q != ST_FINISH) m_tvalid <= 1'b0;
			if (!clr_done_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == AW'(CELLS - 1)) clr_done_q <= 1'b1;
			end
			if (v_s2) begin
				acc_q <= acc_q + prod_s2;
				cov_q <= cov_q & cov_s2;
			end
			case (st_q)
				ST_IDLE: begin
					if (accept) begin
						cov_q    <= 1'b1;
						acc_q    <= '0;
						wr_q     <= 1'b0;
						okflag_q <= 1'b0;
						st_q     <= ST_FINISH;
						case (in_action)
							ACT_WRITE: begin
								wr_q     <= 1'b1;
								okflag_q <= in_inside;
							end
							ACT_READ: begin
								if (ready_q && in_inside) begin
									ix_q     <= CIW'(in_col);
									iy_q     <= RIW'(in_row);
									fx_q     <= '0;
									fy_q     <= '0;
									k_q      <= '0;
									n_q      <= 3'd1;
									okflag_q <= 1'b1;
									st_q     <= ST_READ;
								end
							end
							ACT_INTERP: begin
								if (ready_q) begin
									dx_q <= 34'($signed(in_px)) - 34'(origin_x_q);
									dy_q <= 34'($signed(in_py)) - 34'(origin_y_q);
									st_q <= ST_CHECK;
								end
							end
							default: ;
						endcase
					end
				end
				ST_CHECK: begin
					if (dx_q[33] || dy_q[33] ||
					    (LXW + 1)'(dx_q[32:0]) > (LXW + 1)'(lim_x) ||
					    (LYW + 1)'(dy_q[32:0]) > (LYW + 1)'(lim_y)) begin
						st_q <= ST_FINISH;
					end else begin
						qx_q   <= {dx_q[32:0], 16'd0};
						qy_q   <= {dy_q[32:0], 16'd0};
						rx_q   <= '0;
						ry_q   <= '0;
						dcnt_q <= 6'(DIV_W);
						st_q   <= ST_DIVIDE;
					end
				end
				ST_DIVIDE: begin
					rx_q   <= bx ? (tx - {1'b0, pitch}) : tx;
					ry_q   <= by ? (ty - {1'b0, pitch}) : ty;
					qx_q   <= {qx_q[DIV_W-2:0], bx};
					qy_q   <= {qy_q[DIV_W-2:0], by};
					dcnt_q <= dcnt_q - 6'd1;
					if (dcnt_q == 6'd1) st_q <= ST_SETUP;
				end
				ST_SETUP: begin
					ix_q     <= qx_q[16 +: CIW];
					iy_q     <= qy_q[16 +: RIW];
					k_q      <= '0;
					okflag_q <= 1'b1;
					st_q     <= ST_READ;
					// On the last column or row the single cell is returned unblended.
					if (32'(qx_q[16 +: CIW]) >= 32'(cols_eff) - 1 ||
					    32'(qy_q[16 +: RIW]) >= 32'(rows_eff) - 1) begin
						fx_q <= '0;
						fy_q <= '0;
						n_q  <= 3'd1;
					end else begin
						fx_q <= qx_q[15:0];
						fy_q <= qy_q[15:0];
						n_q  <= 3'd4;
					end
				end
				ST_READ: begin
					if (rd_en) k_q <= k_q + 3'd1;
					else if (!v_s1 && !v_s2) st_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata  <= OUT_W'({(res_ok && !wr_q) ? rnd[63:32] : 32'd0, res_ok});
						st_q     <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	a_busy_after_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> clr_done_q) else $error("item in flight during clear");
	a_pipe_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (st_q == ST_READ)) else $error("product outside read phase");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[32:1] == 32'd0)) else $error("height on fail");
	a_read_count: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_READ) |-> (k_q <= n_q)) else $error("read counter overrun");

endmodule
